FILE: rtl/bftr_pkg.sv
package bftr_pkg;

    localparam int GLYPH_WIDTH = 8;
    localparam int MAX_FONT_HEIGHT = 32;
    localparam logic [12:0] MAX_WRAP_WIDTH = 13'd4096;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;

    localparam logic [7:0] REG_SCREEN_WIDTH = 8'd0;
    localparam logic [7:0] REG_SCREEN_HEIGHT = 8'd1;
    localparam logic [7:0] REG_FONT_HEIGHT = 8'd2;
    localparam logic [7:0] REG_DRAW_COLOR = 8'd3;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [12:0] font_addr;
        logic [7:0]  font_byte;
    } in_item_t;

    typedef struct packed {
        logic [23:0] pixel_offset;
        logic [7:0]  row_bits;
        logic [15:0] color;
        logic        off_screen;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [5:0]  glyph_rows;
        logic [15:0] draw_color;
    } cfg_t;

    // addr: font byte address for a load, glyph base address for a draw
    typedef struct packed {
        logic        is_load;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [23:0] offset;
        logic [15:0] row_y;
    } cmd_t;

    function automatic logic [5:0] eff_height(input logic [5:0] fh);
        logic [5:0] h;
        if (fh == 6'd0)
        begin
            h = 6'd1;
        end
        else if (fh > 6'(MAX_FONT_HEIGHT))
        begin
            h = 6'(MAX_FONT_HEIGHT);
        end
        else
        begin
            h = fh;
        end
        return h;
    endfunction

endpackage

FILE: rtl/bftr_fifo.sv
module bftr_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bftr_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bftr_pkg::cmd_t head
);
    import bftr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic do_push, do_pop;

    always_comb
    begin
        full       = (count_reg == 2'd2);
        head_valid = (count_reg != 2'd0);
        head       = slot_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/bftr_front.sv
module bftr_front #(
    parameter int BORDER_PIXELS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bftr_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  bftr_pkg::in_item_t in_data,
    output logic               cmd_push,
    output bftr_pkg::cmd_t     cmd,
    input  logic               cmd_full
);
    import bftr_pkg::*;

    localparam logic [11:0] BORDER_X = 12'(BORDER_PIXELS);

    logic [11:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;

    logic        accept;
    logic        is_load, is_newline, is_print;
    logic [5:0]  h;
    logic [16:0] y_down;
    logic [15:0] y_sat;
    logic [12:0] x_adv;
    logic [12:0] sw_lim;
    logic        wrap;
    logic [13:0] glyph_base;
    logic [28:0] row_prod;
    logic [28:0] offset_full;

    always_comb
    begin
        in_ready   = !cmd_full;
        accept     = in_valid && !cmd_full;
        h          = eff_height(cfg.glyph_rows);
        is_load    = (in_data.req_type == REQ_LOAD);
        is_newline = (in_data.char_code == CHAR_NEWLINE);
        is_print   = (in_data.char_code >= CHAR_FIRST_PRINT);

        y_down = {1'b0, cursor_y_reg} + 17'(h);
        y_sat  = y_down[16] ? 16'hffff : y_down[15:0];

        // wrap test uses the advanced cursor and the width clamped to 4096
        x_adv  = {1'b0, cursor_x_reg} + 13'(GLYPH_WIDTH);
        sw_lim = (cfg.screen_width > MAX_WRAP_WIDTH) ? MAX_WRAP_WIDTH : cfg.screen_width;
        wrap   = ({1'b0, x_adv} + 14'(GLYPH_WIDTH) + 14'(BORDER_PIXELS)) > {1'b0, sw_lim};

        glyph_base  = 14'(in_data.char_code) * 14'(h);
        row_prod    = 29'(cursor_y_reg) * 29'(cfg.screen_width);
        offset_full = row_prod + 29'(cursor_x_reg);

        cmd.is_load = is_load;
        cmd.addr    = is_load ? in_data.font_addr : glyph_base[12:0];
        cmd.data    = in_data.font_byte;
        cmd.offset  = offset_full[23:0];
        cmd.row_y   = cursor_y_reg;

        cmd_push = accept && (is_load || is_print);

        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (accept && !is_load)
        begin
            if (is_newline)
            begin
                cursor_x_next = BORDER_X;
                cursor_y_next = y_sat;
            end
            else if (is_print)
            begin
                if (wrap)
                begin
                    cursor_x_next = BORDER_X;
                    cursor_y_next = y_sat;
                end
                else
                begin
                    cursor_x_next = x_adv[11:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= BORDER_X;
            cursor_y_reg <= 16'(BORDER_PIXELS);
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

endmodule

FILE: rtl/bftr_back.sv
module bftr_back #(
    parameter int FONT_ADDR_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bftr_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    input  bftr_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output bftr_pkg::out_item_t out_data
);
    import bftr_pkg::*;

    localparam int FONT_DEPTH = 1 << FONT_ADDR_W;

    logic [7:0] font_mem [FONT_DEPTH];

    logic                   busy_reg, busy_next;
    logic [4:0]             row_reg;
    logic [FONT_ADDR_W-1:0] addr_reg;
    logic [23:0]            offset_reg;
    logic [16:0]            row_y_reg;

    logic        out_valid_reg;
    logic [7:0]  rd_data_reg;
    logic [23:0] out_offset_reg;
    logic        out_off_screen_reg;
    logic        out_last_reg;

    logic                   can_issue, issue, mem_we;
    logic [5:0]             h_last;
    logic [4:0]             cur_row;
    logic [FONT_ADDR_W-1:0] cur_addr;
    logic [23:0]            cur_offset;
    logic [16:0]            cur_row_y;
    logic                   cur_last;

    always_comb
    begin
        can_issue = !out_valid_reg || out_ready;
        h_last    = eff_height(cfg.glyph_rows) - 6'd1;

        if (busy_reg)
        begin
            cur_row    = row_reg;
            cur_addr   = addr_reg;
            cur_offset = offset_reg;
            cur_row_y  = row_y_reg;
        end
        else
        begin
            cur_row    = 5'd0;
            cur_addr   = cmd.addr[FONT_ADDR_W-1:0];
            cur_offset = cmd.offset;
            cur_row_y  = {1'b0, cmd.row_y};
        end
        cur_last = ({1'b0, cur_row} == h_last);

        issue     = 1'b0;
        mem_we    = 1'b0;
        cmd_pop   = 1'b0;
        busy_next = busy_reg;

        if (busy_reg)
        begin
            if (can_issue)
            begin
                issue     = 1'b1;
                busy_next = !cur_last;
            end
        end
        else if (cmd_valid)
        begin
            if (cmd.is_load)
            begin
                mem_we  = 1'b1;
                cmd_pop = 1'b1;
            end
            else if (can_issue)
            begin
                // row 0 goes straight from the queue head
                issue     = 1'b1;
                cmd_pop   = 1'b1;
                busy_next = !cur_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            row_reg            <= cur_row + 5'd1;
            addr_reg           <= cur_addr + 1'b1;
            offset_reg         <= cur_offset + 24'(cfg.screen_width);
            row_y_reg          <= cur_row_y + 17'd1;
            out_offset_reg     <= cur_offset;
            out_off_screen_reg <= (cur_row_y >= 17'(cfg.screen_height));
            out_last_reg       <= cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[cmd.addr[FONT_ADDR_W-1:0]] <= cmd.data;
        end
        if (issue)
        begin
            rd_data_reg <= font_mem[cur_addr];
        end
    end

    always_comb
    begin
        out_valid             = out_valid_reg;
        out_data.pixel_offset = out_offset_reg;
        out_data.row_bits     = rd_data_reg;
        out_data.color        = cfg.draw_color;
        out_data.off_screen   = out_off_screen_reg;
        out_data.last         = out_last_reg;
    end

endmodule

FILE: rtl/bitmap_font_text_renderer.sv
// Text console renderer with a loadable 8-pixel-wide font. A load transaction
// (req_type 1) writes one byte of font memory in the back end. A draw
// transaction advances the cursor: newline moves to the left border one font
// height down, other codes below 0x20 are dropped, and a printable code produces
// one result transaction per glyph row (last on the final one) carrying the
// word offset x + row_y * screen_width, the glyph byte (bit 7 leftmost),
// draw_color and an off_screen flag for rows at or below screen_height. The
// back end reads font memory once per glyph row, one row per cycle unless the
// output stalls (1 to 32 rows, 16 at reset); a two-entry command queue lets
// the front keep taking transactions meanwhile, and newline and control codes
// never reach the back end. Font memory contents are undefined until written;
// FONT_BYTES must be a power of two. The user must write registers only while
// the block is idle, which it does not enforce; cfg_ready is always high.
module bitmap_font_text_renderer #(
    parameter int BORDER_PIXELS = 30,
    parameter int FONT_BYTES    = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bftr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bftr_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import bftr_pkg::*;

    localparam int FONT_ADDR_W = $clog2(FONT_BYTES);

    cfg_t cfg_reg;

    logic cmd_push, cmd_full, cmd_valid, cmd_pop;
    cmd_t cmd_in, cmd_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 13'd640;
            cfg_reg.screen_height <= 13'd480;
            cfg_reg.glyph_rows    <= 6'd16;
            cfg_reg.draw_color    <= 16'hffff;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[12:0];
                REG_FONT_HEIGHT:   cfg_reg.glyph_rows    <= cfg_data[5:0];
                REG_DRAW_COLOR:    cfg_reg.draw_color    <= cfg_data;
                default:           ;
            endcase
        end
    end

    bftr_front #(
        .BORDER_PIXELS(BORDER_PIXELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    bftr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_data  (cmd_in),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head       (cmd_head)
    );

    bftr_back #(
        .FONT_ADDR_W(FONT_ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
